// ----- rtl/psl_pkg.sv -----
`default_nettype none
package psl_pkg;

  localparam int PROV_CNT = 4;
  localparam int Q_DEPTH  = 8;

  localparam int PROV_W = (PROV_CNT > 1) ? $clog2(PROV_CNT) : 1;
  localparam int QH_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QF_W   = $clog2(Q_DEPTH + 1);
  localparam int MEM_DEPTH = PROV_CNT * Q_DEPTH;
  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_REG_CNT = 4;

  localparam logic [3:0] LIMIT_RST = 4'd1;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_UNLIMITED = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_HANDED    = 3'd3;
  localparam logic [2:0] ST_FREED     = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  typedef enum logic {
    OP_ACQ,
    OP_REL
  } op_t;

  typedef enum logic {
    BK_EXEC,
    BK_RD
  } bk_state_t;

  typedef struct packed {
    logic       action;
    logic [1:0] provider;
    logic [7:0] requester_tag;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] granted_tag;
    logic       grant_valid;
    logic [1:0] result_provider;
    logic [3:0] active_after;
    logic       queue_full;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic       in_range;
    logic [1:0] provider;
    logic [7:0] tag;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } link_t;

endpackage
`default_nettype wire

// ----- rtl/per_source_concurrency_limiter_top.sv -----
`default_nettype none
// Each request passes the 2-entry request queue and the back end, whose result
// is registered; a release that hands its slot to a queued waiter also reads
// the waiter tag from memory first. One request per cycle while no handoff
// holds the queue; busy rises when the request queue is full. Sync reset
// (rst_n low) empties queues, zeroes counts and sets every limit to 1.
module per_source_concurrency_limiter_top
  import psl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data
);

  logic  q_valid;
  item_t q_item;
  link_t link;

  psl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .pop     (link.pop && link.valid),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  psl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .link      (link),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/psl_front.sv -----
`default_nettype none
module psl_front
  import psl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire in_t   in_data,
  input  wire logic  pop,
  output logic       q_valid,
  output item_t      q_item
);

  item_t      ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  // classify: decode action and range-check provider
  always_comb begin
    cls.provider = in_data.provider;
    cls.tag      = in_data.requester_tag;
    cls.in_range = (32'(in_data.provider) < PROV_CNT);
    case (in_data.action)
      1'b0:    cls.op = OP_ACQ;
      default: cls.op = OP_REL;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/psl_back.sv -----
`default_nettype none
module psl_back
  import psl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output link_t                     link,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]           cfg_data,
  output logic                      out_valid,
  output out_t                      out_data
);

  bk_state_t  state_r, state_nxt;
  logic [3:0] limit_r [PROV_CNT];
  logic [3:0] cnt_r   [PROV_CNT];
  logic [QH_W-1:0] head_r [PROV_CNT];
  logic [QF_W-1:0] fill_r [PROV_CNT];
  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_data_r;
  out_t       hold_r, hold_nxt;
  out_t       out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [PROV_W-1:0] p_idx;
  logic [3:0]        lim, cnt;
  logic [QH_W-1:0]   head;
  logic [QF_W-1:0]   fill;
  logic              handoff;
  logic [QH_W:0]     slot_sum;
  logic [QH_W-1:0]   wr_slot, head_inc;
  logic [MEM_AW-1:0] base;

  logic              pop, upd, mem_we, rd_en;
  logic [3:0]        cnt_nxt;
  logic [QH_W-1:0]   head_nxt;
  logic [QF_W-1:0]   fill_nxt;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [PROV_W-1:0] cfg_idx;

  assign p_idx = PROV_W'(q_item.provider);
  assign lim   = limit_r[p_idx];
  assign cnt   = cnt_r[p_idx];
  assign head  = head_r[p_idx];
  assign fill  = fill_r[p_idx];
  assign base  = MEM_AW'(MEM_AW'(p_idx) * MEM_AW'(Q_DEPTH));

  // tail slot: head + fill wraps at most once
  always_comb begin
    slot_sum = (QH_W + 1)'(head) + (QH_W + 1)'(fill);
    if (32'(slot_sum) >= Q_DEPTH) begin
      wr_slot = QH_W'(slot_sum - (QH_W + 1)'(Q_DEPTH));
    end else begin
      wr_slot = QH_W'(slot_sum);
    end
    if (32'(head) + 1 >= Q_DEPTH) begin
      head_inc = '0;
    end else begin
      head_inc = head + QH_W'(1);
    end
  end

  assign handoff = q_valid && q_item.in_range && (q_item.op == OP_REL) && (fill != '0);
  assign wr_addr = base + MEM_AW'(wr_slot);
  assign rd_addr = base + MEM_AW'(head);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_EXEC: begin
        if (handoff) state_nxt = BK_RD;
      end
      BK_RD: begin
        state_nxt = BK_EXEC;
      end
      default: state_nxt = BK_EXEC;
    endcase
  end

  // outputs and state updates
  always_comb begin
    pop           = 1'b0;
    upd           = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    cnt_nxt       = cnt;
    head_nxt      = head;
    fill_nxt      = fill;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      BK_EXEC: begin
        if (q_valid) begin
          pop = 1'b1;
          out_nxt.status          = ST_IGNORED;
          out_nxt.granted_tag     = 8'd0;
          out_nxt.grant_valid     = 1'b0;
          out_nxt.result_provider = q_item.provider;
          out_nxt.active_after    = 4'd0;
          out_nxt.queue_full      = 1'b0;
          if (q_item.in_range) begin
            upd = 1'b1;
            if (q_item.op == OP_ACQ) begin
              if (lim == 4'd0) begin
                out_nxt.status      = ST_UNLIMITED;
                out_nxt.granted_tag = q_item.tag;
                out_nxt.grant_valid = 1'b1;
              end else if (cnt < lim) begin
                cnt_nxt             = cnt + 4'd1;
                out_nxt.status      = ST_GRANTED;
                out_nxt.granted_tag = q_item.tag;
                out_nxt.grant_valid = 1'b1;
              end else if (32'(fill) < Q_DEPTH) begin
                mem_we         = 1'b1;
                fill_nxt       = fill + QF_W'(1);
                out_nxt.status = ST_QUEUED;
              end else begin
                out_nxt.queue_full = 1'b1;
              end
            end else begin
              if (fill != '0) begin
                rd_en              = 1'b1;
                head_nxt           = head_inc;
                fill_nxt           = fill - QF_W'(1);
                out_nxt.status     = ST_HANDED;
                out_nxt.grant_valid = 1'b1;
              end else if (cnt != 4'd0) begin
                cnt_nxt        = cnt - 4'd1;
                out_nxt.status = ST_FREED;
              end
            end
            out_nxt.active_after = cnt_nxt;
          end
          // handed-off waiter goes out once its tag is read back
          if (handoff) begin
            hold_nxt = out_nxt;
            out_nxt  = out_r;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      BK_RD: begin
        out_nxt             = hold_r;
        out_nxt.granted_tag = rd_data_r;
        out_valid_nxt       = 1'b1;
      end
      default: ;
    endcase
  end

  assign link.valid = q_valid;
  assign link.pop   = pop;
  assign cfg_ready  = 1'b1;
  assign cfg_idx    = PROV_W'(cfg_index);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PROV_CNT; i++) begin
        limit_r[i] <= LIMIT_RST;
        cnt_r[i]   <= 4'd0;
        head_r[i]  <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        cnt_r[p_idx]  <= cnt_nxt;
        head_r[p_idx] <= head_nxt;
        fill_r[p_idx] <= fill_nxt;
      end
      if (cfg_valid && (32'(cfg_index) < CFG_REG_CNT) && (32'(cfg_index) < PROV_CNT)) begin
        limit_r[cfg_idx] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_item.tag;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/psl_checker.sv -----
`default_nettype none
module psl_checker
  import psl_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_data
);

  logic req_acc;

  assign req_acc = start && !busy;

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_grant_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.grant_valid ==
      ((out_data.status == ST_GRANTED) || (out_data.status == ST_UNLIMITED) ||
       (out_data.status == ST_HANDED))))
    else $error("grant_valid disagrees with status");

  a_no_tag_without_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.grant_valid) |-> (out_data.granted_tag == 8'd0))
    else $error("tag reported without a grant");

  a_full_is_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.queue_full) |-> (out_data.status == ST_IGNORED))
    else $error("queue_full on a non-rejected request");

  // worst drain after the last accepted request: two queued handoffs
  a_no_result_without_request: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(req_acc) && !$past(req_acc, 2) && !$past(req_acc, 3) &&
     !$past(req_acc, 4) && !$past(req_acc, 5) && $past(rst_n, 5)) |-> !out_valid)
    else $error("result with no pending request");

endmodule

bind per_source_concurrency_limiter_top psl_checker u_psl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
